[src/vzc_pkg.sv]
// ----------------------------------------------------------------------------
// vzc_pkg
// Shared types, constants, sign-mapping and group-shift functions of the varint codec.
// ----------------------------------------------------------------------------
package vzc_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned NarrowW = 32;
  localparam int unsigned DataBits = 7;

  localparam logic [3:0] NARROW_LIMIT = 4'd5;
  localparam logic [3:0] WIDE_LIMIT = 4'd10;

  // request codes
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_enc;
    logic emit_byte;
    logic dec_step;
  } vzc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_dec;
    logic dec_done;
    logic enc_more;
  } vzc_stat_t;

  // zigzag map at the selected width; narrow results are zero-extended
  function automatic logic [ValueW-1:0] zz_enc(input logic [ValueW-1:0] v,
                                               input logic wide);
    logic [NarrowW-1:0] n;
    logic [ValueW-1:0] r;
    n = {v[NarrowW-2:0], 1'b0} ^ {NarrowW{v[NarrowW-1]}};
    if (wide) begin
      r = {v[ValueW-2:0], 1'b0} ^ {ValueW{v[ValueW-1]}};
    end else begin
      r = {{(ValueW-NarrowW){1'b0}}, n};
    end
    return r;
  endfunction

  function automatic logic [ValueW-1:0] zz_dec(input logic [ValueW-1:0] u,
                                               input logic wide);
    logic [NarrowW-1:0] n;
    logic [ValueW-1:0] r;
    n = {1'b0, u[NarrowW-1:1]} ^ {NarrowW{u[0]}};
    if (wide) begin
      r = {1'b0, u[ValueW-1:1]} ^ {ValueW{u[0]}};
    end else begin
      r = {{(ValueW-NarrowW){1'b0}}, n};
    end
    return r;
  endfunction

  // bit position of the next 7-bit group; count never exceeds 9
  function automatic logic [5:0] grp_shift(input logic [3:0] cnt);
    logic [6:0] s;
    s = {cnt, 3'b000} - {3'b000, cnt};
    return s[5:0];
  endfunction

endpackage

[src/vzc_in_if.sv]
// ----------------------------------------------------------------------------
// vzc_in_if
// Request channel of the varint codec: valid/ready plus request payload.
// ----------------------------------------------------------------------------
interface vzc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] value_in;
  logic [7:0]  byte_in;
  logic        is_signed;
  logic        is_wide;

  modport source (
    output valid, req_type, value_in, byte_in, is_signed, is_wide,
    input  ready
  );
  modport sink (
    input  valid, req_type, value_in, byte_in, is_signed, is_wide,
    output ready
  );
endinterface

[src/vzc_out_if.sv]
// ----------------------------------------------------------------------------
// vzc_out_if
// Result channel of the varint codec: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface vzc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [63:0] decoded_value;
  logic        value_valid;

  modport source (
    output valid, out_byte, byte_valid, last, decoded_value, value_valid,
    input  ready
  );
  modport sink (
    input  valid, out_byte, byte_valid, last, decoded_value, value_valid,
    output ready
  );
endinterface

[src/vzc_dp.sv]
// ----------------------------------------------------------------------------
// vzc_dp
// Codec datapath: encode shift register, decode accumulator and byte count,
// and the result register.
// ----------------------------------------------------------------------------
module vzc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  vzc_pkg::vzc_cmd_t  cmd,
  output vzc_pkg::vzc_stat_t stat,
  input  logic               req_type,
  input  logic [63:0]        value_in,
  input  logic [7:0]         byte_in,
  input  logic               is_signed,
  input  logic               is_wide,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [63:0]        decoded_value,
  output logic               value_valid
);
  import vzc_pkg::*;

  logic [ValueW-1:0] enc_r, enc_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [3:0]        cnt_r, cnt_nxt;

  logic [7:0]        obyte_r, obyte_nxt;
  logic              bvld_r, bvld_nxt;
  logic              last_r, last_nxt;
  logic [ValueW-1:0] dval_r, dval_nxt;
  logic              vvld_r, vvld_nxt;

  logic [ValueW-1:0] in_masked;
  logic [ValueW-1:0] enc_load;
  logic [ValueW-1:0] acc_new;
  logic [ValueW-1:0] acc_masked;
  logic [ValueW-1:0] dec_val;
  logic [3:0]        cnt_inc;
  logic [3:0]        limit;
  logic              more;
  logic              done;

  always_comb begin
    in_masked = is_wide ? value_in : {{(ValueW-NarrowW){1'b0}}, value_in[NarrowW-1:0]};
    enc_load  = is_signed ? zz_enc(in_masked, is_wide) : in_masked;
    more      = |enc_r[ValueW-1:DataBits];

    acc_new    = acc_r | ({{(ValueW-DataBits){1'b0}}, byte_in[DataBits-1:0]}
                          << grp_shift(cnt_r));
    acc_masked = is_wide ? acc_new : {{(ValueW-NarrowW){1'b0}}, acc_new[NarrowW-1:0]};
    dec_val    = is_signed ? zz_dec(acc_masked, is_wide) : acc_masked;
    cnt_inc    = cnt_r + 4'd1;
    limit      = is_wide ? WIDE_LIMIT : NARROW_LIMIT;
    // flag clear, or the width's byte limit reached
    done       = !byte_in[7] || (cnt_inc >= limit);
  end

  assign stat.req_dec  = (req_type == REQ_DECODE);
  assign stat.dec_done = done;
  assign stat.enc_more = more;

  always_comb begin
    enc_nxt   = enc_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    obyte_nxt = obyte_r;
    bvld_nxt  = bvld_r;
    last_nxt  = last_r;
    dval_nxt  = dval_r;
    vvld_nxt  = vvld_r;

    if (cmd.load_enc) begin
      enc_nxt = enc_load;
    end else if (cmd.emit_byte) begin
      enc_nxt   = enc_r >> DataBits;
      obyte_nxt = {more, enc_r[DataBits-1:0]};
      bvld_nxt  = 1'b1;
      last_nxt  = !more;
      dval_nxt  = '0;
      vvld_nxt  = 1'b0;
    end

    if (cmd.dec_step) begin
      if (done) begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        obyte_nxt = '0;
        bvld_nxt  = 1'b0;
        last_nxt  = 1'b0;
        dval_nxt  = dec_val;
        vvld_nxt  = 1'b1;
      end else begin
        acc_nxt = acc_new;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enc_r   <= enc_nxt;
    obyte_r <= obyte_nxt;
    bvld_r  <= bvld_nxt;
    last_r  <= last_nxt;
    dval_r  <= dval_nxt;
    vvld_r  <= vvld_nxt;
  end

  assign out_byte      = obyte_r;
  assign byte_valid    = bvld_r;
  assign last          = last_r;
  assign decoded_value = dval_r;
  assign value_valid   = vvld_r;

endmodule

[src/vzc_ctrl.sv]
// ----------------------------------------------------------------------------
// vzc_ctrl
// Codec controller: accepts requests, sequences encode bytes and owns the
// result register's valid flag.
// ----------------------------------------------------------------------------
module vzc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  vzc_pkg::vzc_stat_t stat,
  output vzc_pkg::vzc_cmd_t  cmd
);
  import vzc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_ENC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  // result register can take new data this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.req_dec) begin
            cmd.dec_step = 1'b1;
            if (stat.dec_done) begin
              out_valid_nxt = 1'b1;
            end
          end else begin
            cmd.load_enc = 1'b1;
            state_nxt    = S_ENC;
          end
        end
      end
      S_ENC: begin
        if (slot_free) begin
          cmd.emit_byte = 1'b1;
          out_valid_nxt = 1'b1;
          if (!stat.enc_more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/varint_zigzag_codec.sv]
// ----------------------------------------------------------------------------
// varint_zigzag_codec
// LEB128-style varint encoder/decoder with optional zigzag sign mapping.
// ----------------------------------------------------------------------------
// Encode: the accept cycle loads the value, then one byte per cycle leaves the
//   shift register. Decode: one byte per cycle; a completed value shows in the
//   cycle after the byte that ends it. The single result register sets both
//   rates: neither flows while it holds a result not yet taken.
// Reset clears the controller, the result valid flag and the decode state.
module varint_zigzag_codec (
  input  logic      clk,
  input  logic      rst_n,
  vzc_in_if.sink    in_ch,
  vzc_out_if.source out_ch
);
  import vzc_pkg::*;

  vzc_cmd_t  cmd;
  vzc_stat_t stat;

  vzc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vzc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (in_ch.req_type),
    .value_in      (in_ch.value_in),
    .byte_in       (in_ch.byte_in),
    .is_signed     (in_ch.is_signed),
    .is_wide       (in_ch.is_wide),
    .out_byte      (out_ch.out_byte),
    .byte_valid    (out_ch.byte_valid),
    .last          (out_ch.last),
    .decoded_value (out_ch.decoded_value),
    .value_valid   (out_ch.value_valid)
  );

  // no new transaction while an encode is still emitting bytes
  a_no_accept_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_byte && in_ch.ready))
    else $error("request accepted during encode emission");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_byte |=> out_ch.valid && out_ch.byte_valid
                      && (out_ch.last == !$past(stat.enc_more)))
    else $error("encoded byte not presented correctly");

  a_dec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && stat.req_dec && stat.dec_done)
      |=> out_ch.valid && out_ch.value_valid)
    else $error("completed decode value not presented");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.byte_valid ^ out_ch.value_valid))
    else $error("result carries both or neither kind");

endmodule
